// ===== rtl/core/i2c_eeprom_master_assert.svh =====
// assertion macros for the i2c eeprom master
// no dependencies
`ifndef I2C_EEPROM_MASTER_ASSERT_SVH
`define I2C_EEPROM_MASTER_ASSERT_SVH

// implication checked on every clock edge outside reset
`define IEM_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the cycle after the antecedent
`define IEM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/iem_pkg.sv =====
// shared types and constants for the i2c eeprom master
// no dependencies
package iem_pkg;

    localparam int BufferDepth = 16;
    localparam int BufAw = (BufferDepth > 1) ? $clog2(BufferDepth) : 1;
    localparam int FillW = $clog2(BufferDepth + 1);

    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_LOAD = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    localparam logic [1:0] REG_DEVICE = 2'd0;
    localparam logic [1:0] REG_PAGE   = 2'd1;
    localparam logic [1:0] REG_WAIT   = 2'd2;

    typedef enum logic [20:0] {
        PH_IDLE       = 21'd1 << 0,
        PH_START_A    = 21'd1 << 1,
        PH_START_B    = 21'd1 << 2,
        PH_TX_SETUP   = 21'd1 << 3,
        PH_TX_HIGH    = 21'd1 << 4,
        PH_TX_LOW     = 21'd1 << 5,
        PH_ACK_SETUP  = 21'd1 << 6,
        PH_ACK_HIGH   = 21'd1 << 7,
        PH_ACK_LOW    = 21'd1 << 8,
        PH_RS_SETUP   = 21'd1 << 9,
        PH_RS_HIGH    = 21'd1 << 10,
        PH_RX_SETUP   = 21'd1 << 11,
        PH_RX_HIGH    = 21'd1 << 12,
        PH_RX_LOW     = 21'd1 << 13,
        PH_MACK_SETUP = 21'd1 << 14,
        PH_MACK_HIGH  = 21'd1 << 15,
        PH_MACK_LOW   = 21'd1 << 16,
        PH_STOP_SETUP = 21'd1 << 17,
        PH_STOP_HIGH  = 21'd1 << 18,
        PH_STOP_END   = 21'd1 << 19,
        PH_WAIT       = 21'd1 << 20
    } phase_t;

    typedef enum logic [3:0] {
        ST_IN   = 4'b0001,
        ST_RD   = 4'b0010,
        ST_EXEC = 4'b0100,
        ST_OUT  = 4'b1000
    } seq_t;

endpackage

// ===== rtl/core/i2c_eeprom_master.sv =====
// i2c eeprom master, tick-paced bit engine with page buffer in a ram
// depends on iem_pkg and i2c_eeprom_master_assert.svh
// sequencing: an accepted item passes through the read and execute states, then its result beat
// is offered; no new item is taken until that beat is taken; the read state registers the
// buffer read and the flush quotient before execute
// reset: asynchronous active low; bus idles high, buffer holds no valid data
`include "i2c_eeprom_master_assert.svh"
module i2c_eeprom_master (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  cmd,
    input  logic        sda_sample,
    input  logic [7:0]  data_byte,
    input  logic [18:0] mem_address,
    input  logic [7:0]  read_length,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        scl_level,
    output logic        sda_level,
    output logic        sda_drive,
    output logic [7:0]  read_byte,
    output logic        read_valid,
    output logic        read_last,
    output logic        nack_seen,
    output logic        busy_res,
    output logic        accepted
);
    import iem_pkg::*;

    // configuration
    logic [7:0]  dev_reg;
    logic [4:0]  page_reg;
    logic [19:0] wait_cfg_reg;

    // bus engine state
    phase_t        phase_reg, phase_next;
    seq_t          seq_reg, seq_next;
    logic [FillW-1:0] fill_reg, fill_next;
    logic [3:0]  bitc_reg, bitc_next;
    logic [7:0]  shift_reg, shift_next;
    logic [7:0]  left_reg, left_next;
    logic [18:0] taddr_reg, taddr_next;
    logic [19:0] waitc_reg, waitc_next;
    logic [8:0]  sidx_reg, sidx_next;
    logic        rd_reg, rd_next, two_reg, two_next;
    logic        scl_reg, scl_next, sda_reg, sda_next, drv_reg, drv_next;

    // latched input item
    logic [1:0]  cmd_reg;
    logic        sin_reg;
    logic [7:0]  dat_reg;
    logic [18:0] adr_reg;
    logic [7:0]  rlen_reg;

    // result beat
    logic [7:0]  rbyte_reg, rbyte_next;
    logic        rval_reg, rval_next, rlast_reg, rlast_next;
    logic        nack_reg, nack_next, acc_reg, acc_next;

    // page buffer ram
    logic [7:0]       buf_mem [BufferDepth];
    logic [7:0]       buf_q;
    logic [BufAw-1:0] buf_raddr;
    logic             buf_we;
    logic [BufAw-1:0] buf_waddr;

    always_ff @(posedge clk)
    begin
        if (buf_we)
        begin
            buf_mem[buf_waddr] <= dat_reg;
        end
        buf_q <= buf_mem[buf_raddr];
    end

    // read address: buffer slot of the data byte the next load needs
    logic [8:0] hlen;
    logic [8:0] rd_idx;
    always_comb
    begin
        hlen = two_reg ? 9'd3 : 9'd2;
        rd_idx = (phase_reg == PH_ACK_LOW) ? (sidx_reg + 9'd1) : sidx_reg;
        rd_idx = rd_idx - hlen;
        buf_raddr = rd_idx[BufAw-1:0];
    end

    // effective page
    logic [FillW-1:0] eff;
    always_comb
    begin
        if (page_reg == 5'd0)
        begin
            eff = FillW'(1);
        end
        else if ({27'd0, page_reg} > BufferDepth)
        begin
            eff = FillW'(BufferDepth);
        end
        else
        begin
            eff = FillW'(page_reg);
        end
    end

    // floor(2^24 / eff), low by less than one so the quotient is at most one short
    logic [24:0] recip;
    always_comb
    begin
        case (eff)
            5'd1:    recip = 25'd16777216;
            5'd2:    recip = 25'd8388608;
            5'd3:    recip = 25'd5592405;
            5'd4:    recip = 25'd4194304;
            5'd5:    recip = 25'd3355443;
            5'd6:    recip = 25'd2796202;
            5'd7:    recip = 25'd2396745;
            5'd8:    recip = 25'd2097152;
            5'd9:    recip = 25'd1864135;
            5'd10:   recip = 25'd1677721;
            5'd11:   recip = 25'd1525201;
            5'd12:   recip = 25'd1398101;
            5'd13:   recip = 25'd1290555;
            5'd14:   recip = 25'd1198372;
            5'd15:   recip = 25'd1118481;
            default: recip = 25'd1048576;
        endcase
    end

    // flush address: quotient registered in the read cycle, one-step fixup at execute
    logic [42:0] quot_prod;
    logic [18:0] quot_reg;
    logic [23:0] flush_base;
    logic [18:0] flush_rem;
    logic [18:0] flush_addr;
    always_comb
    begin
        quot_prod = {24'd0, adr_reg} * {18'd0, recip};
        flush_base = {5'd0, quot_reg} * {19'd0, eff};
        flush_rem = adr_reg - flush_base[18:0];
        flush_addr = flush_base[18:0] + ((flush_rem >= 19'(eff)) ? 19'(eff) : 19'd0);
    end

    // byte at current send index
    function automatic logic [7:0] hdr_byte(input logic [8:0] k, input logic two,
                                            input logic rd, input logic [18:0] ta,
                                            input logic [7:0] dev, input logic [7:0] bq);
        logic [8:0] hi;
        logic [8:0] h;
        logic [8:0] full;
        hi = two ? {5'd0, ta[18:16], 1'b0} : {ta[15:8], 1'b0};
        h = two ? 9'd3 : 9'd2;
        full = {1'b0, dev} | hi;
        if (k == 9'd0)
        begin
            return full[7:0];
        end
        else if (k < h)
        begin
            return (two && k == 9'd1) ? ta[15:8] : ta[7:0];
        end
        else if (rd)
        begin
            return full[7:0] | 8'd1;
        end
        else if (k - h < 9'(BufferDepth))
        begin
            return bq;
        end
        return 8'hff;
    endfunction

    // handshake
    assign in_ready = (seq_reg == ST_IN);

    always_comb
    begin
        seq_next = seq_reg;
        case (seq_reg)
            ST_IN:   if (in_valid) seq_next = ST_RD;
            ST_RD:   seq_next = ST_EXEC;
            ST_EXEC: seq_next = ST_OUT;
            ST_OUT:  if (out_ready) seq_next = ST_IN;
            default: seq_next = ST_IN;
        endcase
    end

    // item execution
    logic busy;
    logic [8:0] sidx_inc;
    always_comb
    begin
        phase_next = phase_reg;
        fill_next = fill_reg;
        bitc_next = bitc_reg;
        shift_next = shift_reg;
        left_next = left_reg;
        taddr_next = taddr_reg;
        waitc_next = waitc_reg;
        sidx_next = sidx_reg;
        rd_next = rd_reg;
        two_next = two_reg;
        scl_next = scl_reg;
        sda_next = sda_reg;
        drv_next = drv_reg;
        rbyte_next = 8'd0;
        rval_next = 1'b0;
        rlast_next = 1'b0;
        nack_next = 1'b0;
        acc_next = 1'b0;
        buf_we = 1'b0;
        buf_waddr = fill_reg[BufAw-1:0];
        busy = (phase_reg != PH_IDLE);
        sidx_inc = sidx_reg + 9'd1;
        if (seq_reg == ST_EXEC)
        begin
            if (cmd_reg == CMD_TICK)
            begin
                acc_next = 1'b1;
                case (phase_reg)
                    PH_IDLE:
                    begin
                        scl_next = 1'b1; sda_next = 1'b1; drv_next = 1'b1;
                    end
                    PH_START_A:
                    begin
                        scl_next = 1'b1; sda_next = 1'b0; drv_next = 1'b1;
                        shift_next = hdr_byte(sidx_reg, two_reg, rd_reg, taddr_reg,
                                              dev_reg, buf_q);
                        bitc_next = 4'd0;
                        phase_next = PH_START_B;
                    end
                    PH_START_B:
                    begin
                        scl_next = 1'b0; sda_next = 1'b0; drv_next = 1'b1;
                        phase_next = PH_TX_SETUP;
                    end
                    PH_TX_SETUP:
                    begin
                        scl_next = 1'b0; sda_next = shift_reg[7]; drv_next = 1'b1;
                        phase_next = PH_TX_HIGH;
                    end
                    PH_TX_HIGH:
                    begin
                        scl_next = 1'b1;
                        phase_next = PH_TX_LOW;
                    end
                    PH_TX_LOW:
                    begin
                        scl_next = 1'b0;
                        shift_next = {shift_reg[6:0], 1'b0};
                        if (bitc_reg == 4'd7)
                        begin
                            bitc_next = 4'd0;
                            phase_next = PH_ACK_SETUP;
                        end
                        else
                        begin
                            bitc_next = bitc_reg + 4'd1;
                            phase_next = PH_TX_SETUP;
                        end
                    end
                    PH_ACK_SETUP:
                    begin
                        scl_next = 1'b0; sda_next = 1'b1; drv_next = 1'b0;
                        phase_next = PH_ACK_HIGH;
                    end
                    PH_ACK_HIGH:
                    begin
                        scl_next = 1'b1;
                        nack_next = sin_reg;
                        phase_next = PH_ACK_LOW;
                    end
                    PH_ACK_LOW:
                    begin
                        scl_next = 1'b0;
                        sidx_next = sidx_inc;
                        if (!rd_reg)
                        begin
                            if (sidx_inc < hlen + {1'b0, left_reg})
                            begin
                                shift_next = hdr_byte(sidx_inc, two_reg, rd_reg, taddr_reg,
                                                      dev_reg, buf_q);
                                bitc_next = 4'd0;
                                phase_next = PH_TX_SETUP;
                            end
                            else
                            begin
                                phase_next = PH_STOP_SETUP;
                            end
                        end
                        else if (sidx_inc < hlen)
                        begin
                            shift_next = hdr_byte(sidx_inc, two_reg, rd_reg, taddr_reg,
                                                  dev_reg, buf_q);
                            bitc_next = 4'd0;
                            phase_next = PH_TX_SETUP;
                        end
                        else if (sidx_inc == hlen)
                        begin
                            phase_next = PH_RS_SETUP;
                        end
                        else if (left_reg == 8'd0)
                        begin
                            phase_next = PH_STOP_SETUP;
                        end
                        else
                        begin
                            bitc_next = 4'd0;
                            shift_next = 8'd0;
                            phase_next = PH_RX_SETUP;
                        end
                    end
                    PH_RS_SETUP:
                    begin
                        scl_next = 1'b0; sda_next = 1'b1; drv_next = 1'b1;
                        phase_next = PH_RS_HIGH;
                    end
                    PH_RS_HIGH:
                    begin
                        scl_next = 1'b1; sda_next = 1'b1; drv_next = 1'b1;
                        phase_next = PH_START_A;
                    end
                    PH_RX_SETUP:
                    begin
                        scl_next = 1'b0; sda_next = 1'b1; drv_next = 1'b0;
                        phase_next = PH_RX_HIGH;
                    end
                    PH_RX_HIGH:
                    begin
                        scl_next = 1'b1;
                        shift_next = {shift_reg[6:0], sin_reg};
                        bitc_next = bitc_reg + 4'd1;
                        if (bitc_reg >= 4'd7)
                        begin
                            rbyte_next = {shift_reg[6:0], sin_reg};
                            rval_next = 1'b1;
                            rlast_next = (left_reg == 8'd1);
                        end
                        phase_next = PH_RX_LOW;
                    end
                    PH_RX_LOW:
                    begin
                        scl_next = 1'b0;
                        phase_next = (bitc_reg >= 4'd8) ? PH_MACK_SETUP : PH_RX_SETUP;
                    end
                    PH_MACK_SETUP:
                    begin
                        scl_next = 1'b0; sda_next = (left_reg <= 8'd1); drv_next = 1'b1;
                        phase_next = PH_MACK_HIGH;
                    end
                    PH_MACK_HIGH:
                    begin
                        scl_next = 1'b1;
                        phase_next = PH_MACK_LOW;
                    end
                    PH_MACK_LOW:
                    begin
                        scl_next = 1'b0;
                        if (left_reg <= 8'd1)
                        begin
                            left_next = 8'd0;
                            phase_next = PH_STOP_SETUP;
                        end
                        else
                        begin
                            left_next = left_reg - 8'd1;
                            bitc_next = 4'd0;
                            shift_next = 8'd0;
                            phase_next = PH_RX_SETUP;
                        end
                    end
                    PH_STOP_SETUP:
                    begin
                        scl_next = 1'b0; sda_next = 1'b0; drv_next = 1'b1;
                        phase_next = PH_STOP_HIGH;
                    end
                    PH_STOP_HIGH:
                    begin
                        scl_next = 1'b1; sda_next = 1'b0; drv_next = 1'b1;
                        phase_next = PH_STOP_END;
                    end
                    PH_STOP_END:
                    begin
                        scl_next = 1'b1; sda_next = 1'b1; drv_next = 1'b1;
                        if (!rd_reg && wait_cfg_reg != 20'd0)
                        begin
                            waitc_next = wait_cfg_reg;
                            phase_next = PH_WAIT;
                        end
                        else
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                    PH_WAIT:
                    begin
                        scl_next = 1'b1; sda_next = 1'b1; drv_next = 1'b1;
                        if (waitc_reg <= 20'd1)
                        begin
                            waitc_next = 20'd0;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            waitc_next = waitc_reg - 20'd1;
                        end
                    end
                    default:
                    begin
                        scl_next = 1'b1; sda_next = 1'b1; drv_next = 1'b1;
                        phase_next = PH_IDLE;
                    end
                endcase
            end
            else if (cmd_reg == CMD_LOAD && !busy)
            begin
                acc_next = 1'b1;
                taddr_next = adr_reg;
                if (fill_reg < eff)
                begin
                    buf_we = 1'b1;
                end
                if (fill_reg + FillW'(1) >= eff)
                begin
                    taddr_next = flush_addr;
                    fill_next = '0;
                    rd_next = 1'b0;
                    two_next = (page_reg >= 5'd16);
                    left_next = 8'(eff);
                    sidx_next = 9'd0;
                    bitc_next = 4'd0;
                    phase_next = PH_START_A;
                end
                else
                begin
                    fill_next = fill_reg + FillW'(1);
                end
            end
            else if (cmd_reg == CMD_READ && !busy)
            begin
                acc_next = 1'b1;
                taddr_next = adr_reg;
                rd_next = 1'b1;
                two_next = (page_reg >= 5'd16);
                left_next = rlen_reg;
                sidx_next = 9'd0;
                bitc_next = 4'd0;
                phase_next = PH_START_A;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_reg <= 8'ha0;
            page_reg <= 5'd16;
            wait_cfg_reg <= 20'd1000;
            seq_reg <= ST_IN;
            phase_reg <= PH_IDLE;
            fill_reg <= '0;
            bitc_reg <= 4'd0;
            shift_reg <= 8'd0;
            left_reg <= 8'd0;
            taddr_reg <= 19'd0;
            waitc_reg <= 20'd0;
            sidx_reg <= 9'd0;
            rd_reg <= 1'b0;
            two_reg <= 1'b0;
            scl_reg <= 1'b1;
            sda_reg <= 1'b1;
            drv_reg <= 1'b1;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DEVICE: dev_reg <= cfg_data[7:0];
                    REG_PAGE:   page_reg <= cfg_data[4:0];
                    REG_WAIT:   wait_cfg_reg <= cfg_data;
                    default:    ;
                endcase
            end
            seq_reg <= seq_next;
            phase_reg <= phase_next;
            fill_reg <= fill_next;
            bitc_reg <= bitc_next;
            shift_reg <= shift_next;
            left_reg <= left_next;
            taddr_reg <= taddr_next;
            waitc_reg <= waitc_next;
            sidx_reg <= sidx_next;
            rd_reg <= rd_next;
            two_reg <= two_next;
            scl_reg <= scl_next;
            sda_reg <= drv_next ? sda_next : 1'b1;
            drv_reg <= drv_next;
        end
    end

    // input beat and result beat payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg <= cmd;
            sin_reg <= sda_sample;
            dat_reg <= data_byte;
            adr_reg <= mem_address;
            rlen_reg <= read_length;
        end
        if (seq_reg == ST_RD)
        begin
            quot_reg <= quot_prod[42:24];
        end
        if (seq_reg == ST_EXEC)
        begin
            rbyte_reg <= rbyte_next;
            rval_reg <= rval_next;
            rlast_reg <= rlast_next;
            nack_reg <= nack_next;
            acc_reg <= acc_next;
        end
    end

    assign out_valid = (seq_reg == ST_OUT);
    assign scl_level = scl_reg;
    assign sda_level = sda_reg;
    assign sda_drive = drv_reg;
    assign read_byte = rbyte_reg;
    assign read_valid = rval_reg;
    assign read_last = rlast_reg;
    assign nack_seen = nack_reg;
    assign busy_res = (phase_reg != PH_IDLE);
    assign accepted = acc_reg;

    // checks
    `IEM_ASSERT_IMP(a_phase_onehot, 1'b1, $onehot(phase_reg), "phase not one-hot")
    `IEM_ASSERT_IMP(a_release_high, !drv_reg, sda_reg, "released sda not high")
    `IEM_ASSERT_NEXT(a_exec_to_out, seq_reg == ST_EXEC, seq_reg == ST_OUT,
        "result beat not offered after execute")
    `IEM_ASSERT_IMP(a_fill_bound, 1'b1, fill_reg < FillW'(BufferDepth),
        "fill count past buffer")
endmodule

// ===== tb/sv/tb_i2c_eeprom_master.sv =====
// self-checking testbench for the i2c eeprom master: tick-level bus model,
// page writes, reads, refused requests and config changes under random idling
// depends on iem_pkg and the i2c_eeprom_master rtl
module tb_i2c_eeprom_master;
    import iem_pkg::*;

    typedef struct packed {
        logic [1:0]  cmd;
        logic        sda;
        logic [7:0]  data;
        logic [18:0] addr;
        logic [7:0]  len;
    } req_t;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       drive;
        logic [7:0] rbyte;
        logic       rvalid;
        logic       rlast;
        logic       nack;
        logic       busy;
        logic       acc;
    } bus_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [19:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  cmd = '0;
    logic        sda_sample = 1'b0;
    logic [7:0]  data_byte = '0;
    logic [18:0] mem_address = '0;
    logic [7:0]  read_length = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    bus_t        got;

    req_t pending_reqs[$];
    bus_t expected_bus[$];
    int   errors = 0;
    int   send_idle = 0;
    int   recv_idle = 0;
    bit   hold_req = 1'b0;
    int   hold_left = 0;
    int   long_reads = 0;

    // bus model state and its copy of the registers
    logic [7:0]  m_dev;
    logic [4:0]  m_page;
    logic [19:0] m_wait;
    logic [7:0]  m_buf [BufferDepth];
    int unsigned m_fill, m_bitc, m_shr, m_left, m_tadr, m_waitc, m_sidx;
    phase_t      m_ph;
    bit          m_rd, m_two, m_scl, m_sda, m_drv;

    i2c_eeprom_master dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd),
        .sda_sample(sda_sample), .data_byte(data_byte), .mem_address(mem_address),
        .read_length(read_length), .out_valid(out_valid), .out_ready(out_ready),
        .scl_level(got.scl), .sda_level(got.sda), .sda_drive(got.drive),
        .read_byte(got.rbyte), .read_valid(got.rvalid), .read_last(got.rlast),
        .nack_seen(got.nack), .busy_res(got.busy), .accepted(got.acc)
    );

    always #2 clk = ~clk;

    function automatic int unsigned eff_page();
        int unsigned p;
        p = m_page;
        if (p == 0) p = 1;
        if (p > BufferDepth) p = BufferDepth;
        return p;
    endfunction

    function automatic int unsigned hdr_len();
        return m_two ? 3 : 2;
    endfunction

    // byte k of the current transaction, header first
    function automatic int unsigned frame_byte(int unsigned k);
        int unsigned hi;
        hi = m_two ? ((m_tadr & 32'h00ff0000) >> 15) : ((m_tadr & 32'h0000ff00) >> 7);
        if (k == 0) return (m_dev | hi) & 8'hff;
        if (k < hdr_len()) return (m_two && k == 1) ? ((m_tadr >> 8) & 8'hff) : (m_tadr & 8'hff);
        if (m_rd) return (m_dev | hi | 1) & 8'hff;
        if (k - hdr_len() < BufferDepth) return m_buf[k - hdr_len()];
        return 8'hff;
    endfunction

    task automatic set_lines(bit s, bit d, bit dr);
        m_scl = s;
        m_sda = dr ? d : 1'b1;
        m_drv = dr;
    endtask

    task automatic load_byte();
        m_shr = frame_byte(m_sidx);
        m_bitc = 0;
        m_ph = PH_TX_SETUP;
    endtask

    task automatic begin_xfer(bit rd, int unsigned len);
        m_rd = rd;
        m_two = m_page >= 16;
        m_left = len & 8'hff;
        m_sidx = 0;
        m_bitc = 0;
        m_ph = PH_START_A;
    endtask

    task automatic bus_reset();
        m_dev = 8'ha0; m_page = 5'd16; m_wait = 20'd1000;
        foreach (m_buf[i]) m_buf[i] = '0;
        m_fill = 0; m_ph = PH_IDLE; m_bitc = 0; m_shr = 0; m_left = 0;
        m_tadr = 0; m_waitc = 0; m_sidx = 0; m_rd = 0; m_two = 0;
        set_lines(1, 1, 1);
    endtask

    // one bus tick of the bit engine
    task automatic bus_tick(bit sda_in, inout bus_t r);
        case (m_ph)
            PH_START_A: begin
                set_lines(1, 0, 1);
                m_shr = frame_byte(m_sidx);
                m_bitc = 0;
                m_ph = PH_START_B;
            end
            PH_START_B: begin set_lines(0, 0, 1); m_ph = PH_TX_SETUP; end
            PH_TX_SETUP: begin set_lines(0, m_shr[7], 1); m_ph = PH_TX_HIGH; end
            PH_TX_HIGH: begin m_scl = 1; m_ph = PH_TX_LOW; end
            PH_TX_LOW: begin
                m_scl = 0;
                m_shr = (m_shr << 1) & 8'hff;
                m_bitc++;
                if (m_bitc >= 8) begin m_bitc = 0; m_ph = PH_ACK_SETUP; end
                else m_ph = PH_TX_SETUP;
            end
            PH_ACK_SETUP: begin set_lines(0, 1, 0); m_ph = PH_ACK_HIGH; end
            PH_ACK_HIGH: begin m_scl = 1; r.nack = sda_in; m_ph = PH_ACK_LOW; end
            PH_ACK_LOW: begin
                m_scl = 0;
                m_sidx++;
                if (!m_rd) begin
                    if (m_sidx < hdr_len() + m_left) load_byte();
                    else m_ph = PH_STOP_SETUP;
                end
                else if (m_sidx < hdr_len()) load_byte();
                else if (m_sidx == hdr_len()) m_ph = PH_RS_SETUP;
                else if (m_left == 0) m_ph = PH_STOP_SETUP;
                else begin m_bitc = 0; m_shr = 0; m_ph = PH_RX_SETUP; end
            end
            PH_RS_SETUP: begin set_lines(0, 1, 1); m_ph = PH_RS_HIGH; end
            PH_RS_HIGH: begin set_lines(1, 1, 1); m_ph = PH_START_A; end
            PH_RX_SETUP: begin set_lines(0, 1, 0); m_ph = PH_RX_HIGH; end
            PH_RX_HIGH: begin
                m_scl = 1;
                m_shr = ((m_shr << 1) | sda_in) & 8'hff;
                m_bitc++;
                if (m_bitc >= 8) begin
                    r.rbyte = m_shr[7:0];
                    r.rvalid = 1;
                    r.rlast = (m_left == 1);
                end
                m_ph = PH_RX_LOW;
            end
            PH_RX_LOW: begin
                m_scl = 0;
                m_ph = (m_bitc >= 8) ? PH_MACK_SETUP : PH_RX_SETUP;
            end
            PH_MACK_SETUP: begin set_lines(0, m_left <= 1, 1); m_ph = PH_MACK_HIGH; end
            PH_MACK_HIGH: begin m_scl = 1; m_ph = PH_MACK_LOW; end
            PH_MACK_LOW: begin
                m_scl = 0;
                if (m_left > 0) m_left--;
                if (m_left == 0) m_ph = PH_STOP_SETUP;
                else begin m_bitc = 0; m_shr = 0; m_ph = PH_RX_SETUP; end
            end
            PH_STOP_SETUP: begin set_lines(0, 0, 1); m_ph = PH_STOP_HIGH; end
            PH_STOP_HIGH: begin set_lines(1, 0, 1); m_ph = PH_STOP_END; end
            PH_STOP_END: begin
                set_lines(1, 1, 1);
                if (!m_rd && m_wait != 0) begin m_waitc = m_wait; m_ph = PH_WAIT; end
                else m_ph = PH_IDLE;
            end
            PH_WAIT: begin
                set_lines(1, 1, 1);
                if (m_waitc > 0) m_waitc--;
                if (m_waitc == 0) m_ph = PH_IDLE;
            end
            default: begin set_lines(1, 1, 1); m_ph = PH_IDLE; end
        endcase
    endtask

    // predicted bus levels and flags for one request
    task automatic predict_bus(input req_t q, output bus_t r);
        bit busy;
        int unsigned eff;
        busy = (m_ph != PH_IDLE);
        r = '0;
        if (q.cmd == CMD_TICK) begin
            r.acc = 1;
            bus_tick(q.sda, r);
        end
        else if (q.cmd == CMD_LOAD && !busy) begin
            r.acc = 1;
            eff = eff_page();
            m_tadr = q.addr;
            if (m_fill < eff && m_fill < BufferDepth) begin
                m_buf[m_fill] = q.data;
                m_fill++;
            end
            if (m_fill >= eff) begin
                m_tadr = (q.addr / eff) * eff;
                m_fill = 0;
                begin_xfer(0, eff);
            end
        end
        else if (q.cmd == CMD_READ && !busy) begin
            r.acc = 1;
            m_tadr = q.addr;
            begin_xfer(1, q.len);
        end
        r.scl = m_scl;
        r.sda = m_sda;
        r.drive = m_drv;
        r.busy = (m_ph != PH_IDLE);
    endtask

    task automatic queue_req(logic [1:0] c, logic s, logic [7:0] d, logic [18:0] a,
                             logic [7:0] l);
        req_t q;
        bus_t r;
        q = '{cmd: c, sda: s, data: d, addr: a, len: l};
        predict_bus(q, r);
        pending_reqs.push_back(q);
        expected_bus.push_back(r);
    endtask

    task automatic tick_to_idle();
        while (m_ph != PH_IDLE) queue_req(CMD_TICK, 1'($urandom_range(1)), '0, '0, '0);
    endtask

    // wait for the block to drain, then write all three registers
    task automatic write_regs(logic [7:0] dev, logic [4:0] page, logic [19:0] wt);
        wait (pending_reqs.size() == 0 && !in_valid && expected_bus.size() == 0);
        repeat (8) @(posedge clk);
        cfg_we <= 1'b1; cfg_index <= REG_DEVICE; cfg_data <= {12'd0, dev};
        @(posedge clk);
        cfg_index <= REG_PAGE; cfg_data <= {15'd0, page};
        @(posedge clk);
        cfg_index <= REG_WAIT; cfg_data <= wt;
        @(posedge clk);
        cfg_we <= 1'b0;
        m_dev = dev; m_page = page; m_wait = wt;
    endtask

    // random requests, mostly well-formed when idle, noise while busy
    task automatic random_reqs(int n, bit reads_only);
        int r;
        logic [7:0] len;
        repeat (n) begin
            r = int'($urandom_range(99));
            len = 8'($urandom_range(3));
            if ($urandom_range(99) < 2 && long_reads < 4) begin
                len = 8'($urandom_range(255));
                long_reads++;
            end
            if (m_ph == PH_IDLE) begin
                if (r < 45 && !reads_only)
                    queue_req(CMD_LOAD, 1'($urandom_range(1)), 8'($urandom), 19'($urandom),
                              8'($urandom));
                else if (r < 65)
                    queue_req(CMD_READ, 1'($urandom_range(1)), 8'($urandom), 19'($urandom),
                              len);
                else if (r < 70)
                    queue_req(2'd3, 1'($urandom_range(1)), 8'($urandom), 19'($urandom),
                              8'($urandom));
                else
                    queue_req(CMD_TICK, 1'($urandom_range(1)), 8'($urandom), 19'($urandom),
                              8'($urandom));
            end
            else begin
                if (r < 3 && !reads_only)
                    queue_req(CMD_LOAD, 1'($urandom_range(1)), 8'($urandom), 19'($urandom),
                              8'($urandom));
                else if (r < 6)
                    queue_req(CMD_READ, 1'($urandom_range(1)), 8'($urandom), 19'($urandom),
                              8'($urandom));
                else if (r < 9)
                    queue_req(2'd3, 1'($urandom_range(1)), 8'($urandom), 19'($urandom),
                              8'($urandom));
                else
                    queue_req(CMD_TICK, 1'($urandom_range(1)), 8'($urandom), 19'($urandom),
                              8'($urandom));
            end
        end
        tick_to_idle();
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle)
            begin
                req_t q;
                q = pending_reqs.pop_front();
                in_valid <= 1'b1;
                cmd <= q.cmd;
                sda_sample <= q.sda;
                data_byte <= q.data;
                mem_address <= q.addr;
                read_length <= q.len;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_bus.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected beat, actual %p", $time, got);
                end
                else
                begin
                    bus_t e;
                    e = expected_bus.pop_front();
                    if (e.scl !== got.scl || e.sda !== got.sda || e.drive !== got.drive ||
                        e.rbyte !== got.rbyte || e.rvalid !== got.rvalid ||
                        e.rlast !== got.rlast || e.nack !== got.nack ||
                        e.busy !== got.busy || e.acc !== got.acc)
                    begin
                        errors++;
                        $display("%0t: mismatch, expected %p actual %p", $time, e, got);
                    end
                end
            end
            // long hold-off so the block backs up into its input
            if (hold_req && hold_left == 0)
            begin
                hold_left = 400;
                hold_req = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle);
            end
        end
    end

    initial
    begin
        #4000000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        bus_reset();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: one-byte pages, no write wait
        write_regs(8'ha0, 5'd1, 20'd0);
        queue_req(CMD_LOAD, 1'b1, 8'hff, 19'h7ffff, 8'hff);
        queue_req(CMD_READ, 1'b0, 8'h00, 19'h00000, 8'h01);
        queue_req(CMD_LOAD, 1'b0, 8'h00, 19'h00000, 8'h00);
        tick_to_idle();
        queue_req(CMD_READ, 1'b0, 8'h00, 19'h00000, 8'h00);
        tick_to_idle();
        queue_req(2'd3, 1'b1, 8'hff, 19'h7ffff, 8'hff);
        queue_req(CMD_TICK, 1'b1, 8'h00, 19'h00000, 8'h00);
        queue_req(CMD_READ, 1'b1, 8'h5a, 19'h7ffff, 8'h02);
        tick_to_idle();
        queue_req(CMD_LOAD, 1'b0, 8'h00, 19'h00000, 8'h00);
        tick_to_idle();

        // two-byte addressing, receiver stalls plus a long hold-off
        write_regs(8'hfe, 5'd16, 20'd3);
        send_idle = 0; recv_idle = 61; hold_req = 1'b1;
        random_reqs(130, 1'b0);

        // sender idles, small pages
        write_regs(8'h00, 5'd4, 20'd0);
        send_idle = 61; recv_idle = 0;
        random_reqs(130, 1'b0);

        // oversize page clamps, both sides idle a little
        write_regs(8'h51, 5'd31, 20'd5);
        send_idle = 8; recv_idle = 8;
        random_reqs(130, 1'b0);

        // longest write wait, reads only so it is never entered
        write_regs(8'hff, 5'd15, 20'hfffff);
        send_idle = 0; recv_idle = 0;
        random_reqs(80, 1'b1);

        // page size zero with a partly filled page drops and flushes
        write_regs(8'($urandom), 5'd0, 20'd20);
        send_idle = 0; recv_idle = 61;
        random_reqs(110, 1'b0);

        write_regs(8'ha1, 5'd2, 20'd1);
        send_idle = 61; recv_idle = 61;
        random_reqs(80, 1'b0);

        wait (pending_reqs.size() == 0 && !in_valid && expected_bus.size() == 0);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/iem_pkg.sv
rtl/core/i2c_eeprom_master.sv
tb/sv/tb_i2c_eeprom_master.sv
